FILE: hdl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, op codes and fixed-point helpers for the posed shape box core.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int FRACTION_BITS = 16;

  // magnitude of a product after the fraction shift, signed product, wide sum
  localparam int MAG_W  = 64 - FRACTION_BITS;
  localparam int PROD_W = MAG_W + 1;
  localparam int SUM_W  = MAG_W + 3;

  typedef logic signed [31:0]       word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_w_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t FX_ONE   = 32'sd1 <<< FRACTION_BITS;

  localparam logic [2:0] OP_ROT_ROW = 3'd0;
  localparam logic [2:0] OP_TRANS   = 3'd1;
  localparam logic [2:0] OP_SPHERE  = 3'd2;
  localparam logic [2:0] OP_CAPSULE = 3'd3;
  localparam logic [2:0] OP_BOX     = 3'd4;
  localparam logic [2:0] OP_VERTEX  = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  row_index;
    word_t       vec_x;
    word_t       vec_y;
    word_t       vec_z;
    logic [30:0] radius;
    logic [30:0] half_height;
    logic        last;
  } in_item_t;

  typedef struct packed {
    word_t min_x;
    word_t min_y;
    word_t min_z;
    word_t max_x;
    word_t max_y;
    word_t max_z;
  } out_item_t;

  // item after the product stage
  typedef struct packed {
    logic [2:0]       op;
    logic             last;
    logic [30:0]      radius;
    word_t [2:0]      trans;
    prod_t [2:0][2:0] prod;
  } stage_item_t;

  function automatic logic [31:0] abs_word(input word_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic word_t sat_word(input sum_w_t v);
    sum_w_t wmax;
    sum_w_t wmin;
    wmax = sum_w_t'(WORD_MAX);
    wmin = sum_w_t'(WORD_MIN);
    if (v > wmax) begin
      return WORD_MAX;
    end else if (v < wmin) begin
      return WORD_MIN;
    end else begin
      return word_t'(v[31:0]);
    end
  endfunction

endpackage

FILE: hdl/psa_mult.sv
// ----------------------------------------------------------------------------
// psa_mult
// Nine magnitude multipliers against the rotation, sign restored, registered.
// ----------------------------------------------------------------------------
module psa_mult import psa_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  in_item_t         item,
  input  word_t [2:0][2:0] rot,
  input  word_t [2:0]      trans,
  output stage_item_t      stage
);

  stage_item_t stage_next;

  always_comb begin
    word_t             vec [3];
    logic [31:0]       mag_a;
    logic [31:0]       mag_b;
    logic [63:0]       full;
    logic [MAG_W-1:0]  mag_p;
    prod_t             pos;
    logic              neg;
    vec[0] = item.vec_x;
    vec[1] = item.vec_y;
    vec[2] = item.vec_z;
    stage_next.op     = item.op;
    stage_next.last   = item.last;
    stage_next.radius = item.radius;
    stage_next.trans  = trans;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mag_a = abs_word(rot[i][j]);
        // capsule uses the local z column scaled by the half height
        if (item.op == OP_CAPSULE && j == 2) begin
          mag_b = {1'b0, item.half_height};
        end else begin
          mag_b = abs_word(vec[j]);
        end
        full  = 64'(mag_a) * 64'(mag_b);
        mag_p = full[63:FRACTION_BITS];
        if (item.op == OP_VERTEX) begin
          neg = rot[i][j][31] ^ vec[j][31];
        end else if (item.op == OP_BOX) begin
          neg = vec[j][31];
        end else begin
          neg = 1'b0;
        end
        pos = prod_t'({1'b0, mag_p});
        stage_next.prod[i][j] = neg ? -pos : pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= stage_next;
    end
  end

endmodule

FILE: hdl/psa_bound.sv
// ----------------------------------------------------------------------------
// psa_bound
// Sums products into extents or vertices, folds the hull, registers results.
// ----------------------------------------------------------------------------
module psa_bound import psa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  stage_item_t stage,
  output logic        emit,
  output out_item_t   result
);

  word_t [2:0] hull_low;
  word_t [2:0] hull_high;
  word_t [2:0] low_next;
  word_t [2:0] high_next;
  out_item_t   result_next;
  logic        is_vertex;

  assign is_vertex = (stage.op == OP_VERTEX);
  assign emit = (stage.op == OP_SPHERE) || (stage.op == OP_CAPSULE) ||
                (stage.op == OP_BOX) || (is_vertex && stage.last);

  always_comb begin
    sum_w_t sum [3];
    sum_w_t t   [3];
    sum_w_t ext [3];
    sum_w_t rad;
    word_t  vert [3];
    word_t  lo   [3];
    word_t  hi   [3];
    rad = sum_w_t'(stage.radius);
    for (int i = 0; i < 3; i++) begin
      t[i]   = sum_w_t'(stage.trans[i]);
      sum[i] = sum_w_t'(stage.prod[i][0]) + sum_w_t'(stage.prod[i][1]) +
               sum_w_t'(stage.prod[i][2]);
      vert[i] = sat_word(t[i] + sum[i]);
      unique case (stage.op)
        OP_SPHERE:  ext[i] = rad;
        OP_CAPSULE: ext[i] = sum_w_t'(stage.prod[i][2]) + rad;
        OP_BOX:     ext[i] = sum[i][SUM_W-1] ? -sum[i] : sum[i];
        default:    ext[i] = '0;
      endcase
      lo[i] = sat_word(t[i] - ext[i]);
      hi[i] = sat_word(t[i] + ext[i]);
      low_next[i]  = (vert[i] < hull_low[i])  ? vert[i] : hull_low[i];
      high_next[i] = (vert[i] > hull_high[i]) ? vert[i] : hull_high[i];
    end
    if (is_vertex) begin
      result_next.min_x = low_next[0];
      result_next.min_y = low_next[1];
      result_next.min_z = low_next[2];
      result_next.max_x = high_next[0];
      result_next.max_y = high_next[1];
      result_next.max_z = high_next[2];
    end else begin
      result_next.min_x = lo[0];
      result_next.min_y = lo[1];
      result_next.min_z = lo[2];
      result_next.max_x = hi[0];
      result_next.max_y = hi[1];
      result_next.max_z = hi[2];
    end
  end

  // running hull, restarts after the last vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      hull_low  <= {3{WORD_MAX}};
      hull_high <= {3{WORD_MIN}};
    end else if (fire && is_vertex) begin
      if (stage.last) begin
        hull_low  <= {3{WORD_MAX}};
        hull_high <= {3{WORD_MIN}};
      end else begin
        hull_low  <= low_next;
        hull_high <= high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result <= result_next;
    end
  end

endmodule

FILE: hdl/posed_shape_aabb_core.sv
// ----------------------------------------------------------------------------
// posed_shape_aabb_core
// Axis-aligned box of a sphere, capsule, box or vertex hull posed by a stored
// rotation and translation, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// throughput: one item per cycle when out_ready does not stall, set by the
//   three-register pipeline (input register, product register, result register)
// reset: synchronous; rotation goes to identity, translation to zero, the
//   hull accumulation is emptied and all pipeline stages are invalid
module posed_shape_aabb_core import psa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // pipeline occupancy
  logic a_valid;
  logic b_valid;
  logic a_fire;
  logic b_fire;
  logic b_ready;
  logic out_free;
  logic emit;

  in_item_t    a_item;
  stage_item_t b_item;

  // pose state, sampled by the item leaving the input register
  word_t [2:0][2:0] rot;
  word_t [2:0]      trans;

  // ready ripples back from the output register
  assign out_free = !out_valid || out_ready;
  assign b_fire   = b_valid && out_free;
  assign b_ready  = !b_valid || out_free;
  assign a_fire   = a_valid && b_ready;
  assign in_ready = !a_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= (in_valid && in_ready) || (a_valid && !a_fire);
      b_valid   <= a_fire || (b_valid && !b_fire);
      out_valid <= (b_fire && emit) || (out_valid && !out_ready);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item <= in_data;
    end
  end

  // pose loads commit when the item moves on, so the next item sees them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot[i][j] <= (i == j) ? FX_ONE : '0;
        end
        trans[i] <= '0;
      end
    end else if (a_fire) begin
      if (a_item.op == OP_ROT_ROW) begin
        // row index three leaves the rotation alone
        for (int i = 0; i < 3; i++) begin
          if (a_item.row_index == 2'(i)) begin
            rot[i][0] <= a_item.vec_x;
            rot[i][1] <= a_item.vec_y;
            rot[i][2] <= a_item.vec_z;
          end
        end
      end else if (a_item.op == OP_TRANS) begin
        trans[0] <= a_item.vec_x;
        trans[1] <= a_item.vec_y;
        trans[2] <= a_item.vec_z;
      end
    end
  end

  // products against the current pose
  psa_mult u_mult (
    .clk   (clk),
    .load  (a_fire),
    .item  (a_item),
    .rot   (rot),
    .trans (trans),
    .stage (b_item)
  );

  // extents, hull fold and result register
  psa_bound u_bound (
    .clk    (clk),
    .rst    (rst),
    .fire   (b_fire),
    .stage  (b_item),
    .emit   (emit),
    .result (out_data)
  );

endmodule

FILE: hdl/psa_check.sv
// ----------------------------------------------------------------------------
// psa_check
// Port-level checks for the posed shape box core, bound to the top level.
// ----------------------------------------------------------------------------
module psa_check import psa_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // an empty output register means the whole pipeline can move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a result waiting for the sink holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // every box is well formed
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.min_x <= out_data.max_x) &&
                  (out_data.min_y <= out_data.max_y) &&
                  (out_data.min_z <= out_data.max_z))
    else $error("box lower corner above upper corner");

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind posed_shape_aabb_core psa_check u_check (.*);

FILE: test/posed_shape_aabb_core_tb.sv
// ----------------------------------------------------------------------------
// posed_shape_aabb_core_tb
// Self-checking bench for the posed shape box core. A directed list covers
// identity and saturating boxes, every op, ignored items and extreme poses;
// random traffic then streams loads, shapes and vertex hulls with random gaps
// on both sides and one long output hold-off. Every box is checked field by
// field against a behavioral predictor or the box written in a typed row.
// ----------------------------------------------------------------------------
module posed_shape_aabb_core_tb;
  import psa_pkg::*;

  localparam int RANDOM_ITEMS    = 1200;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MAX_REPORTS     = 10;

  // op codes the core does not decode, and the row index it ignores
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam logic [1:0] ROW_NONE    = 2'd3;

  localparam longint LONG_MAX = 64'sd2147483647;
  localparam longint LONG_MIN = -64'sd2147483648;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t box;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // predictor copy of the pose and the running hull
  word_t  pose_rot [3][3];
  word_t  pose_trans [3];
  longint hull_lo [3];
  longint hull_hi [3];

  out_item_t expected_boxes [$];
  dir_row_t  directed_rows [$];

  int mismatch_count = 0;
  int boxes_seen     = 0;
  int sent_count     = 0;
  int gap_mode       = 0;
  bit holding_off    = 1'b0;

  posed_shape_aabb_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // box predictor
  // ---------------------------------------------------------------------------

  // exact product, magnitude truncated by the fraction shift, sign restored
  function automatic longint fx_mul(input longint a, input longint b);
    longint ma;
    longint mb;
    longint p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb) >> FRACTION_BITS;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic word_t clamp_word(input longint v);
    if (v > LONG_MAX) begin
      return WORD_MAX;
    end else if (v < LONG_MIN) begin
      return WORD_MIN;
    end
    return word_t'(v[31:0]);
  endfunction

  function automatic out_item_t corners(input longint lo [3], input longint hi [3]);
    out_item_t b;
    b.min_x = clamp_word(lo[0]);
    b.min_y = clamp_word(lo[1]);
    b.min_z = clamp_word(lo[2]);
    b.max_x = clamp_word(hi[0]);
    b.max_y = clamp_word(hi[1]);
    b.max_z = clamp_word(hi[2]);
    return b;
  endfunction

  function automatic void clear_pose();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pose_rot[i][j] = (i == j) ? FX_ONE : word_t'(0);
      end
      pose_trans[i] = '0;
      hull_lo[i] = LONG_MAX;
      hull_hi[i] = LONG_MIN;
    end
  endfunction

  function automatic void predict_box(input in_item_t it, output bit has_box,
                                      output out_item_t box);
    longint vec [3];
    longint ext [3];
    longint lo [3];
    longint hi [3];
    longint acc;
    longint rabs;
    vec[0] = longint'(it.vec_x);
    vec[1] = longint'(it.vec_y);
    vec[2] = longint'(it.vec_z);
    has_box = 1'b0;
    box = '0;
    case (it.op)
      OP_ROT_ROW: begin
        if (it.row_index != ROW_NONE) begin
          pose_rot[it.row_index][0] = it.vec_x;
          pose_rot[it.row_index][1] = it.vec_y;
          pose_rot[it.row_index][2] = it.vec_z;
        end
        return;
      end
      OP_TRANS: begin
        pose_trans[0] = it.vec_x;
        pose_trans[1] = it.vec_y;
        pose_trans[2] = it.vec_z;
        return;
      end
      OP_SPHERE: begin
        for (int i = 0; i < 3; i++) ext[i] = longint'(it.radius);
      end
      OP_CAPSULE: begin
        // local z axis of the pose, scaled by the half height
        for (int i = 0; i < 3; i++) begin
          acc = fx_mul(longint'(it.half_height), longint'(pose_rot[i][2]));
          ext[i] = ((acc < 0) ? -acc : acc) + longint'(it.radius);
        end
      end
      OP_BOX: begin
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) begin
            rabs = longint'(pose_rot[i][j]);
            if (rabs < 0) rabs = -rabs;
            acc += fx_mul(rabs, vec[j]);
          end
          ext[i] = (acc < 0) ? -acc : acc;
        end
      end
      OP_VERTEX: begin
        for (int i = 0; i < 3; i++) begin
          acc = longint'(pose_trans[i]);
          for (int j = 0; j < 3; j++) acc += fx_mul(longint'(pose_rot[i][j]), vec[j]);
          acc = longint'(clamp_word(acc));
          if (acc < hull_lo[i]) hull_lo[i] = acc;
          if (acc > hull_hi[i]) hull_hi[i] = acc;
        end
        if (it.last) begin
          box = corners(hull_lo, hull_hi);
          has_box = 1'b1;
          for (int i = 0; i < 3; i++) begin
            hull_lo[i] = LONG_MAX;
            hull_hi[i] = LONG_MIN;
          end
        end
        return;
      end
      default: return;
    endcase
    // sphere, capsule and box share the symmetric extent around the translation
    for (int i = 0; i < 3; i++) begin
      lo[i] = longint'(pose_trans[i]) - ext[i];
      hi[i] = longint'(pose_trans[i]) + ext[i];
    end
    box = corners(lo, hi);
    has_box = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders and random field values
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(input logic [2:0] op, input logic [1:0] row,
                                         input word_t x, input word_t y, input word_t z,
                                         input logic [30:0] radius,
                                         input logic [30:0] half_height,
                                         input logic last);
    in_item_t it;
    it.op          = op;
    it.row_index   = row;
    it.vec_x       = x;
    it.vec_y       = y;
    it.vec_z       = z;
    it.radius      = radius;
    it.half_height = half_height;
    it.last        = last;
    return it;
  endfunction

  function automatic out_item_t even_box(input word_t lo, input word_t hi);
    out_item_t b;
    b.min_x = lo;
    b.min_y = lo;
    b.min_z = lo;
    b.max_x = hi;
    b.max_y = hi;
    b.max_z = hi;
    return b;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed,
                                  input out_item_t box);
    dir_row_t r;
    r.item  = it;
    r.typed = typed;
    r.box   = box;
    directed_rows.push_back(r);
  endfunction

  // every field filled with random bits, the caller then sets what the op reads
  function automatic in_item_t noise_item();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return in_item_t'(bits[$bits(in_item_t)-1:0]);
  endfunction

  function automatic word_t rnd_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3, 4:    return word_t'($urandom);
      default: return word_t'($urandom_range(0, 32 << FRACTION_BITS)) -
                      word_t'(16 << FRACTION_BITS);
    endcase
  endfunction

  // rotation entries mostly within one unit, so boxes stay meaningful
  function automatic word_t rnd_rot_entry();
    if ($urandom_range(0, 9) < 8) begin
      return word_t'($urandom_range(0, 2 * FX_ONE)) - FX_ONE;
    end
    return rnd_word();
  endfunction

  function automatic logic [30:0] rnd_len();
    case ($urandom_range(0, 9))
      0:       return 31'h7fff_ffff;
      1:       return '0;
      2, 3:    return 31'($urandom);
      default: return 31'($urandom_range(0, 8 << FRACTION_BITS));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side: random gap, then hold the item until the core takes it
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_box);
    int gap;
    bit has_box;
    out_item_t box;
    sent_count++;
    if (sent_count % 64 == 0) gap_mode = $urandom_range(0, 2);
    gap = 0;
    if (!holding_off) begin
      case (gap_mode)
        1: if ($urandom_range(0, 9) >= 7) gap = $urandom_range(1, 3);
        2: begin
          if ($urandom_range(0, 9) == 0) begin
            gap = $urandom_range(10, 40);
          end else if ($urandom_range(0, 9) >= 5) begin
            gap = $urandom_range(1, 4);
          end
        end
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    // taken at this edge: the box (if any) joins the queue in item order
    predict_box(it, has_box, box);
    if (has_box) expected_boxes.push_back(typed ? typed_box : box);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random ready with one long hold-off while traffic keeps coming
  // ---------------------------------------------------------------------------
  initial begin : ready_gen
    int span;
    bit pressure_done;
    pressure_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && boxes_seen >= 400) begin
        // pipeline fills up and in_ready must drop
        pressure_done = 1'b1;
        holding_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holding_off = 1'b0;
      end
      if ($urandom_range(0, 99) < 55) begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 40);
      end else begin
        out_ready <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 50) : $urandom_range(1, 3);
      end
      repeat (span) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("box %0d %s: expected %h got %h", boxes_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      boxes_seen++;
      if (expected_boxes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("box %0d: unexpected item %h", boxes_seen, out_data);
        end
      end else begin
        want = expected_boxes.pop_front();
        compare_field("min_x", want.min_x, out_data.min_x);
        compare_field("min_y", want.min_y, out_data.min_y);
        compare_field("min_z", want.min_z, out_data.min_z);
        compare_field("max_x", want.max_x, out_data.max_x);
        compare_field("max_y", want.max_y, out_data.max_y);
        compare_field("max_z", want.max_z, out_data.max_z);
      end
    end
  end

  // watchdog: cycles in a row with no item moving on either side
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t it;
    int real_items;
    int pick;
    int run_len;
    out_item_t none_box;
    word_t half;
    none_box = '0;
    half = FX_ONE >>> 1;
    real_items = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    clear_pose();

    // directed list; typed boxes follow directly from the identity pose
    add_row(make_item(OP_SPHERE, 0, 0, 0, 0, 31'd0, 31'd0, 1'b0), 1'b1,
            even_box('0, '0));
    add_row(make_item(OP_SPHERE, 0, 0, 0, 0, 31'h7fff_ffff, 31'd0, 1'b0), 1'b1,
            even_box(32'sh8000_0001, WORD_MAX));
    add_row(make_item(OP_CAPSULE, 0, 0, 0, 0, 31'(half), 31'(2 * FX_ONE), 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_BOX, 0, FX_ONE, 2 * FX_ONE, -3 * FX_ONE, 31'd0, 31'd0, 1'b0),
            1'b0, none_box);
    // hull with a sphere dropped in between its vertices
    add_row(make_item(OP_VERTEX, 0, FX_ONE, 2 * FX_ONE, 3 * FX_ONE, 31'd0, 31'd0, 1'b0),
            1'b0, none_box);
    add_row(make_item(OP_SPHERE, 0, 0, 0, 0, 31'(FX_ONE), 31'd0, 1'b0), 1'b0, none_box);
    add_row(make_item(OP_VERTEX, 0, -4 * FX_ONE, 5 * FX_ONE, -6 * FX_ONE, 31'd0, 31'd0,
                      1'b1), 1'b0, none_box);
    // single-vertex hull at the word extremes
    add_row(make_item(OP_VERTEX, 0, WORD_MAX, WORD_MIN, 0, 31'd0, 31'd0, 1'b1), 1'b0,
            none_box);
    // saturation of the translated sphere, both directions
    add_row(make_item(OP_TRANS, 0, WORD_MAX, WORD_MAX, WORD_MAX, 31'd0, 31'd0, 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_SPHERE, 0, 0, 0, 0, 31'h7fff_ffff, 31'd0, 1'b0), 1'b1,
            even_box('0, WORD_MAX));
    add_row(make_item(OP_TRANS, 0, WORD_MIN, WORD_MIN, WORD_MIN, 31'd0, 31'd0, 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_SPHERE, 0, 0, 0, 0, 31'h7fff_ffff, 31'd0, 1'b0), 1'b1,
            even_box(WORD_MIN, 32'shffff_ffff));
    // unused op codes and the unused row index leave everything alone
    add_row(make_item(OP_UNUSED_A, 1, WORD_MAX, WORD_MIN, FX_ONE, 31'h7fff_ffff,
                      31'h7fff_ffff, 1'b0), 1'b0, none_box);
    add_row(make_item(OP_UNUSED_B, 2, WORD_MIN, WORD_MAX, -FX_ONE, 31'd5, 31'd7, 1'b1),
            1'b0, none_box);
    add_row(make_item(OP_ROT_ROW, ROW_NONE, WORD_MIN, WORD_MIN, WORD_MIN, 31'd0, 31'd0,
                      1'b0), 1'b0, none_box);
    add_row(make_item(OP_TRANS, 0, 0, 0, 0, 31'd0, 31'd0, 1'b0), 1'b0, none_box);
    add_row(make_item(OP_SPHERE, 0, 0, 0, 0, 31'd0, 31'd0, 1'b1), 1'b1, even_box('0, '0));
    // extreme pose, then capsule, box and a vertex hull through it
    add_row(make_item(OP_ROT_ROW, 2'd0, WORD_MIN, WORD_MAX, -FX_ONE, 31'd0, 31'd0, 1'b0),
            1'b0, none_box);
    add_row(make_item(OP_ROT_ROW, 2'd1, WORD_MAX, WORD_MIN, 0, 31'd0, 31'd0, 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_ROT_ROW, 2'd2, half, -half, WORD_MIN, 31'd0, 31'd0, 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_CAPSULE, 0, 0, 0, 0, 31'h7fff_ffff, 31'h7fff_ffff, 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_BOX, 0, WORD_MIN, WORD_MAX, WORD_MIN, 31'd0, 31'd0, 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_VERTEX, 0, WORD_MAX, WORD_MAX, WORD_MAX, 31'd0, 31'd0, 1'b0), 1'b0,
            none_box);
    add_row(make_item(OP_VERTEX, 0, WORD_MIN, WORD_MIN, WORD_MIN, 31'd0, 31'd0, 1'b1), 1'b0,
            none_box);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].box);
    end

    // random traffic: mostly poses, shapes and complete hulls
    while (real_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      it = noise_item();
      if (pick < 8) begin
        it.op = OP_ROT_ROW;
        it.row_index = 2'($urandom_range(0, 3));
        it.vec_x = rnd_rot_entry();
        it.vec_y = rnd_rot_entry();
        it.vec_z = rnd_rot_entry();
        if (it.row_index != ROW_NONE) real_items++;
        send_item(it, 1'b0, none_box);
      end else if (pick < 13) begin
        it.op = OP_TRANS;
        it.vec_x = rnd_word();
        it.vec_y = rnd_word();
        it.vec_z = rnd_word();
        real_items++;
        send_item(it, 1'b0, none_box);
      end else if (pick < 58) begin
        // one of the three closed shapes
        it.op = (pick < 28) ? OP_SPHERE : (pick < 43) ? OP_CAPSULE : OP_BOX;
        it.radius = rnd_len();
        it.half_height = rnd_len();
        it.vec_x = rnd_word();
        it.vec_y = rnd_word();
        it.vec_z = rnd_word();
        real_items++;
        send_item(it, 1'b0, none_box);
      end else if (pick < 93) begin
        // well-formed hull, now and then with a shape slipped in between
        run_len = $urandom_range(1, 6);
        for (int k = 0; k < run_len; k++) begin
          it = noise_item();
          it.op = OP_VERTEX;
          it.vec_x = rnd_word();
          it.vec_y = rnd_word();
          it.vec_z = rnd_word();
          it.last = (k == run_len - 1);
          real_items++;
          send_item(it, 1'b0, none_box);
          if (k < run_len - 1 && $urandom_range(0, 9) == 0) begin
            it = noise_item();
            it.op = OP_SPHERE;
            it.radius = rnd_len();
            real_items++;
            send_item(it, 1'b0, none_box);
          end
        end
      end else if (pick < 97) begin
        // broken hull: a vertex left open, the next hull folds it in
        it.op = OP_VERTEX;
        it.vec_x = rnd_word();
        it.vec_y = rnd_word();
        it.vec_z = rnd_word();
        it.last = 1'b0;
        real_items++;
        send_item(it, 1'b0, none_box);
      end else begin
        it.op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_A : OP_UNUSED_B;
        send_item(it, 1'b0, none_box);
      end
    end

    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
